// ===== design/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
// No dependencies; bpa_dp, bpa_ctrl and bitmap_page_allocator import this package.
`default_nettype none

package bpa_pkg;

  localparam int FIELD_W  = 64;
  localparam int CMD_W    = 2;
  localparam int RSV_W    = 16;
  localparam int ADDR_W   = 27;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 2'd0,
    CMD_RESERVE = 2'd1,
    CMD_ALLOC   = 2'd2,
    CMD_FREE    = 2'd3
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OOM     = 2'd2;

  // Map write operations issued by the controller.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_ZERO,
    WR_FILL,
    WR_SET_RANGE,
    WR_SET_FIRST,
    WR_CLEAR_BIT
  } wr_op_t;

  typedef struct packed {
    logic                accept;
    logic                decode;
    logic                cnt_inc;
    logic                rd_en;
    wr_op_t              wr_op;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic                res_found;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t req_cmd;
    logic bad;
    logic rd_vld;
    logic hit;
    logic cnt_at_top;
    logic cnt_at_end;
    logic rd_at_top;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/bpa_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/bpa_dp.sv =====
// Datapath of the page allocator: request registers, decode, word counter,
// map RAM with read-modify-write logic and the result register.
// Depends on bpa_pkg and bpa_ram.
`default_nettype none

module bpa_dp #(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12,
  parameter int WORD_BITS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bpa_pkg::CMD_W-1:0]     in_cmd,
  input  logic [bpa_pkg::FIELD_W-1:0]   in_addr_start,
  input  logic [bpa_pkg::FIELD_W-1:0]   in_addr_end,
  input  logic                          cfg_wr_en,
  input  logic [bpa_pkg::RSV_W-1:0]     cfg_wr_data,
  input  bpa_pkg::dp_cmd_t              cmd,
  output bpa_pkg::dp_stat_t             stat,
  output logic [bpa_pkg::ADDR_W-1:0]    out_page_addr,
  output logic                          out_found,
  output logic [bpa_pkg::STATUS_W-1:0]  out_status
);

  import bpa_pkg::*;

  localparam int LB        = $clog2(WORD_BITS);
  localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW        = $clog2(NUM_PAGES + 1);
  localparam int PAD_BITS  = MAP_WORDS * WORD_BITS - NUM_PAGES;

  localparam logic [WORD_BITS-1:0] ONES     = '1;
  localparam logic [WORD_BITS-1:0] ONE_LSB  = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] PAD_MASK = ~(ONES >> PAD_BITS);
  localparam logic [WA-1:0]        TOP_WORD = WA'(MAP_WORDS - 1);
  localparam logic [LB-1:0]        TOP_BIT  = LB'(WORD_BITS - 1);
  localparam logic [FIELD_W-1:0]   NUM_F    = FIELD_W'(NUM_PAGES);
  localparam logic [PW-1:0]        NUM_P    = PW'(NUM_PAGES);
  localparam logic [PW-1:0]        LAST_P   = PW'(NUM_PAGES - 1);

  // Request and decode registers.
  cmd_t               cmd_r;
  logic [FIELD_W-1:0] a0_r;
  logic [FIELD_W-1:0] a1_r;
  logic [RSV_W-1:0]   rsv_r;
  logic               bad_r, bad_nxt;
  logic [PW-1:0]      pg_a_r, pg_a_nxt;
  logic [PW-1:0]      pg_b_r, pg_b_nxt;

  // Scan state.
  logic [WA-1:0]      wcnt_r, wcnt_nxt;
  logic               rd_vld_r;
  logic [WA-1:0]      rd_addr_r;
  logic [ADDR_W-1:0]  alloc_addr_r;

  // Result register.
  logic [ADDR_W-1:0]   out_page_addr_r;
  logic                out_found_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [FIELD_W-1:0] a0_pg, a1_last, page_byte;
  logic [WA-1:0]      start_word, lo_word, hi_word;
  logic [PW-1:0]      lim_word, wcnt_ext;
  logic [WORD_BITS-1:0] rdata, word_eff, first_zero, range_mask, fill_word;
  logic [WORD_BITS-1:0] mask_lo, mask_hi;
  logic [LB-1:0]      hit_idx;
  logic               hit;
  logic               ram_we;
  logic [WA-1:0]      ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;

  // Decode of the latched request.
  always_comb begin
    a0_pg    = a0_r >> PAGE_SHIFT;
    a1_last  = (a1_r - FIELD_W'(1)) >> PAGE_SHIFT;
    bad_nxt  = 1'b0;
    pg_a_nxt = pg_a_r;
    pg_b_nxt = pg_b_r;
    unique case (cmd_r)
      CMD_INIT: begin
        pg_b_nxt = (32'(rsv_r) > 32'(NUM_PAGES)) ? NUM_P : PW'(rsv_r);
      end
      CMD_RESERVE: begin
        bad_nxt  = (a1_r <= a0_r) || (a0_pg >= NUM_F);
        pg_a_nxt = PW'(a0_pg);
        // The last page is ceil(end / page) - 1, which equals (end - 1) >> shift.
        pg_b_nxt = (a1_last >= NUM_F) ? LAST_P : PW'(a1_last);
      end
      CMD_ALLOC: begin
        pg_a_nxt = '0;
      end
      CMD_FREE: begin
        bad_nxt  = (a0_r == '0) || (|a0_r[PAGE_SHIFT-1:0]) || (a0_pg >= NUM_F);
        pg_a_nxt = PW'(a0_pg);
      end
    endcase
    start_word = ((cmd_r == CMD_RESERVE) || (cmd_r == CMD_FREE)) ?
                 WA'(pg_a_nxt >> LB) : '0;
  end

  always_comb begin
    wcnt_nxt = wcnt_r;
    if (cmd.decode) begin
      wcnt_nxt = start_word;
    end else if (cmd.cnt_inc) begin
      wcnt_nxt = (wcnt_r == TOP_WORD) ? '0 : wcnt_r + WA'(1);
    end
  end

  // Lowest free page in the word just read; pages past the end count as used.
  always_comb begin
    word_eff   = rdata | ((rd_addr_r == TOP_WORD) ? PAD_MASK : '0);
    first_zero = ~word_eff & (word_eff + ONE_LSB);
    hit        = ~&word_eff;
    hit_idx    = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (first_zero[b]) begin
        hit_idx = hit_idx | LB'(b);
      end
    end
    page_byte = FIELD_W'({rd_addr_r, hit_idx}) << PAGE_SHIFT;
  end

  // Range mask for reserve and fill pattern for init.
  always_comb begin
    lo_word    = WA'(pg_a_r >> LB);
    hi_word    = WA'(pg_b_r >> LB);
    mask_lo    = (rd_addr_r == lo_word) ? (ONES << pg_a_r[LB-1:0]) : ONES;
    mask_hi    = (rd_addr_r == hi_word) ? (ONES >> (TOP_BIT - pg_b_r[LB-1:0])) : ONES;
    range_mask = mask_lo & mask_hi;
    lim_word   = pg_b_r >> LB;
    wcnt_ext   = PW'(wcnt_r);
    if (wcnt_ext < lim_word) begin
      fill_word = ONES;
    end else if (wcnt_ext == lim_word) begin
      fill_word = ~(ONES << pg_b_r[LB-1:0]);
    end else begin
      fill_word = '0;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_addr_r;
    ram_wdata = rdata;
    unique case (cmd.wr_op)
      WR_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = wcnt_r;
        ram_wdata = '0;
      end
      WR_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = wcnt_r;
        ram_wdata = fill_word;
      end
      WR_SET_RANGE: begin
        ram_we    = rd_vld_r;
        ram_wdata = rdata | range_mask;
      end
      WR_SET_FIRST: begin
        ram_we    = rd_vld_r && hit;
        ram_wdata = rdata | first_zero;
      end
      WR_CLEAR_BIT: begin
        ram_we    = rd_vld_r;
        ram_wdata = rdata & ~(ONE_LSB << pg_a_r[LB-1:0]);
      end
      default: begin
      end
    endcase
  end

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (wcnt_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r          <= '0;
      rd_vld_r        <= 1'b0;
      rsv_r           <= '0;
      out_page_addr_r <= '0;
      out_found_r     <= 1'b0;
      out_status_r    <= ST_DONE;
    end else begin
      wcnt_r   <= wcnt_nxt;
      rd_vld_r <= cmd.rd_en;
      if (cfg_wr_en) begin
        rsv_r <= cfg_wr_data;
      end
      if (cmd.res_load) begin
        out_status_r    <= cmd.res_status;
        out_found_r     <= cmd.res_found;
        out_page_addr_r <= cmd.res_found ? alloc_addr_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= cmd_t'(in_cmd);
      a0_r  <= in_addr_start;
      a1_r  <= in_addr_end;
    end
    if (cmd.decode) begin
      bad_r  <= bad_nxt;
      pg_a_r <= pg_a_nxt;
      pg_b_r <= pg_b_nxt;
    end
    if (cmd.rd_en) begin
      rd_addr_r <= wcnt_r;
    end
    if ((cmd.wr_op == WR_SET_FIRST) && rd_vld_r && hit) begin
      alloc_addr_r <= page_byte[ADDR_W-1:0];
    end
  end

  always_comb begin
    stat.req_cmd    = cmd_r;
    stat.bad        = bad_r;
    stat.rd_vld     = rd_vld_r;
    stat.hit        = hit;
    stat.cnt_at_top = (wcnt_r == TOP_WORD);
    stat.cnt_at_end = (wcnt_r == hi_word);
    stat.rd_at_top  = (rd_addr_r == TOP_WORD);
  end

  assign out_page_addr = out_page_addr_r;
  assign out_found     = out_found_r;
  assign out_status    = out_status_r;

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && cmd.rd_en) |-> (ram_waddr != wcnt_r))
    else $error("map written and read at the same word");

  a_found_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_found_r |-> (out_status_r == ST_DONE))
    else $error("found result carries a failure status");

  a_addr_only_when_found: assert property (@(posedge clk) disable iff (!rst_n)
    !out_found_r |-> (out_page_addr_r == '0))
    else $error("page address set on a result without a page");

endmodule

`default_nettype wire

// ===== design/bpa_ctrl.sv =====
// Controller state machine of the page allocator.
// Depends on bpa_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module bpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bpa_pkg::dp_stat_t stat,
  output bpa_pkg::dp_cmd_t  cmd
);

  import bpa_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_INIT,
    S_RSV_RD,
    S_RSV_WR,
    S_ALLOC,
    S_FREE_RD,
    S_FREE_WR,
    S_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_found_r, res_found_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.wr_op      = WR_NONE;
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.wr_op   = WR_ZERO;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_at_top) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        unique case (stat.req_cmd)
          CMD_INIT:    state_nxt = S_INIT;
          CMD_RESERVE: state_nxt = S_RSV_RD;
          CMD_ALLOC:   state_nxt = S_ALLOC;
          CMD_FREE:    state_nxt = S_FREE_RD;
        endcase
      end
      S_INIT: begin
        cmd.wr_op   = WR_FILL;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_at_top) begin
          state_nxt      = S_RESP;
          res_status_nxt = ST_DONE;
          res_found_nxt  = 1'b0;
        end
      end
      S_RSV_RD: begin
        if (stat.bad) begin
          state_nxt      = S_RESP;
          res_status_nxt = ST_INVALID;
          res_found_nxt  = 1'b0;
        end else begin
          cmd.wr_op   = WR_SET_RANGE;
          cmd.rd_en   = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (stat.cnt_at_end) begin
            state_nxt = S_RSV_WR;
          end
        end
      end
      S_RSV_WR: begin
        cmd.wr_op      = WR_SET_RANGE;
        state_nxt      = S_RESP;
        res_status_nxt = ST_DONE;
        res_found_nxt  = 1'b0;
      end
      S_ALLOC: begin
        cmd.wr_op = WR_SET_FIRST;
        priority if (stat.rd_vld && stat.hit) begin
          state_nxt      = S_RESP;
          res_status_nxt = ST_DONE;
          res_found_nxt  = 1'b1;
        end else if (stat.rd_vld && stat.rd_at_top) begin
          state_nxt      = S_RESP;
          res_status_nxt = ST_OOM;
          res_found_nxt  = 1'b0;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_FREE_RD: begin
        if (stat.bad) begin
          state_nxt      = S_RESP;
          res_status_nxt = ST_INVALID;
          res_found_nxt  = 1'b0;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        cmd.wr_op      = WR_CLEAR_BIT;
        state_nxt      = S_RESP;
        res_status_nxt = ST_DONE;
        res_found_nxt  = 1'b0;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.res_status = res_status_r;
    cmd.res_found  = res_found_r;

    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_valid_r  <= 1'b0;
      res_status_r <= ST_DONE;
      res_found_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      res_status_r <= res_status_nxt;
      res_found_r  <= res_found_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result presented outside the response step");

  a_hit_reports_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC && stat.rd_vld && stat.hit) |=>
      (state_r == S_RESP && res_found_r))
    else $error("free page found but not reported");

endmodule

`default_nettype wire

// ===== design/bitmap_page_allocator.sv =====
// One request is in work at a time; the next is taken in the cycle after the result
// is loaded, later if an older result still waits. After the synchronous reset all MAP_WORDS
// map words (ceil(NUM_PAGES/WORD_BITS), 512 with the defaults) are cleared one word per cycle
// with input stalled; the init page-count register resets to 0 and is writable whenever
// reset is released.
`default_nettype none

module bitmap_page_allocator #(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12,
  parameter int WORD_BITS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bpa_pkg::CMD_W-1:0]     in_cmd,
  input  logic [bpa_pkg::FIELD_W-1:0]   in_addr_start,
  input  logic [bpa_pkg::FIELD_W-1:0]   in_addr_end,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bpa_pkg::ADDR_W-1:0]    out_page_addr,
  output logic                          out_found,
  output logic [bpa_pkg::STATUS_W-1:0]  out_status,
  // Init page-count register: the number of lowest pages that init marks used.
  input  logic                          cfg_wr_en,
  input  logic [bpa_pkg::RSV_W-1:0]     cfg_wr_data
);

  import bpa_pkg::*;

  // The map keeps one used bit per page in a RAM of WORD_BITS-bit words. WORD_BITS must be
  // a power of two. The controller sequences each request: a decode step checks the range
  // or address, then it sweeps, scans or read-modify-writes map words through the datapath.
  // Alloc reads one word per cycle, stopping at the first zero-bit word or the top word.
  // Reserve reads word k+1 while writing word k, so the read and write ports never collide.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  bpa_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cmd        (in_cmd),
    .in_addr_start (in_addr_start),
    .in_addr_end   (in_addr_end),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .out_page_addr (out_page_addr),
    .out_found     (out_found),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire
